/* hdl/md5_pkg.sv */
`default_nettype none

package md5_pkg;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hEFCDAB89;
  localparam logic [31:0] INIT_C = 32'h98BADCFE;
  localparam logic [31:0] INIT_D = 32'h10325476;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;

  typedef enum logic [1:0] {
    BSEL_IN,
    BSEL_MARK,
    BSEL_ZERO,
    BSEL_LEN
  } byte_sel_t;

  typedef struct packed {
    logic      put_byte;
    byte_sel_t byte_sel;
    logic      add_len;
    logic      round_init;
    logic      round_step;
    logic      load_out;
    logic      reinit;
  } md5_cmd_t;

  typedef struct packed {
    logic pos_at_56;
    logic pos_at_63;
    logic rnd_last;
  } md5_sts_t;

  function automatic logic [31:0] sine_const(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] l;
    logic [3:0] idx;
    l = r[3:0];
    case (r[5:4])
      2'd0: idx = l;
      2'd1: idx = l * 4'd5 + 4'd1;
      2'd2: idx = l * 4'd3 + 4'd5;
      default: idx = l * 4'd7;
    endcase
    return idx;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] dbl;
    dbl = {x, x} << n;
    return dbl[63:32];
  endfunction

endpackage

`default_nettype wire

/* hdl/md5_dp.sv */
`default_nettype none

module md5_dp (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [7:0]       in_byte,
  input  wire md5_pkg::md5_cmd_t cmd,
  output md5_pkg::md5_sts_t      sts,
  output logic [127:0]          digest
);

  logic [5:0]  pos_r;
  logic [63:0] len_r;
  logic [5:0]  rnd_r;
  logic [31:0] chain_r [4];
  logic [31:0] blk_r   [16];
  logic [31:0] rw_r    [4];
  logic [31:0] pre_r;
  logic [127:0] out_r;

  logic [7:0]  put_val;
  logic [31:0] f_val;
  logic [31:0] t_val;
  logic [31:0] nb_val;
  logic [5:0]  rnd_nxt;
  logic [31:0] pre_nxt;
  logic [31:0] pre_init;

  always_comb begin
    case (cmd.byte_sel)
      md5_pkg::BSEL_IN:   put_val = in_byte;
      md5_pkg::BSEL_MARK: put_val = md5_pkg::PAD_MARK;
      md5_pkg::BSEL_LEN:  put_val = len_r[{pos_r[2:0], 3'b000} +: 8];
      default:            put_val = 8'd0;
    endcase
  end

  always_comb begin
    case (rnd_r[5:4])
      2'd0: f_val = (rw_r[1] & rw_r[2]) | (~rw_r[1] & rw_r[3]);
      2'd1: f_val = (rw_r[3] & rw_r[1]) | (~rw_r[3] & rw_r[2]);
      2'd2: f_val = rw_r[1] ^ rw_r[2] ^ rw_r[3];
      default: f_val = rw_r[2] ^ (rw_r[1] | ~rw_r[3]);
    endcase
  end

  // The previous cycle already summed a, the round constant and the message word.
  assign t_val    = f_val + pre_r;
  assign nb_val   = rw_r[1] + md5_pkg::rotl32(t_val, md5_pkg::rot_amount(rnd_r));
  assign rnd_nxt  = rnd_r + 6'd1;
  assign pre_nxt  = rw_r[3] + md5_pkg::sine_const(rnd_nxt) + blk_r[md5_pkg::msg_index(rnd_nxt)];
  assign pre_init = chain_r[0] + md5_pkg::sine_const(6'd0) + blk_r[4'd0];

  assign sts.pos_at_56 = (pos_r == md5_pkg::LEN_POS);
  assign sts.pos_at_63 = (pos_r == md5_pkg::LAST_POS);
  assign sts.rnd_last  = (rnd_r == 6'd63);
  assign digest        = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= 6'd0;
      len_r      <= 64'd0;
      rnd_r      <= 6'd0;
      chain_r[0] <= md5_pkg::INIT_A;
      chain_r[1] <= md5_pkg::INIT_B;
      chain_r[2] <= md5_pkg::INIT_C;
      chain_r[3] <= md5_pkg::INIT_D;
    end else if (cmd.reinit) begin
      pos_r      <= 6'd0;
      len_r      <= 64'd0;
      rnd_r      <= 6'd0;
      chain_r[0] <= md5_pkg::INIT_A;
      chain_r[1] <= md5_pkg::INIT_B;
      chain_r[2] <= md5_pkg::INIT_C;
      chain_r[3] <= md5_pkg::INIT_D;
    end else begin
      if (cmd.put_byte) begin
        pos_r <= pos_r + 6'd1;
      end
      if (cmd.add_len) begin
        len_r <= len_r + 64'd8;
      end
      if (cmd.round_init) begin
        rnd_r <= 6'd0;
      end else if (cmd.round_step) begin
        rnd_r <= rnd_nxt;
        if (sts.rnd_last) begin
          chain_r[0] <= chain_r[0] + rw_r[3];
          chain_r[1] <= chain_r[1] + nb_val;
          chain_r[2] <= chain_r[2] + rw_r[1];
          chain_r[3] <= chain_r[3] + rw_r[2];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put_byte) begin
      if (pos_r[1:0] == 2'd0) begin
        blk_r[pos_r[5:2]] <= {24'd0, put_val};
      end else begin
        blk_r[pos_r[5:2]][{pos_r[1:0], 3'b000} +: 8] <= put_val;
      end
    end
    if (cmd.round_init) begin
      rw_r[0] <= chain_r[0];
      rw_r[1] <= chain_r[1];
      rw_r[2] <= chain_r[2];
      rw_r[3] <= chain_r[3];
      pre_r   <= pre_init;
    end else if (cmd.round_step) begin
      rw_r[0] <= rw_r[3];
      rw_r[1] <= nb_val;
      rw_r[2] <= rw_r[1];
      rw_r[3] <= rw_r[2];
      pre_r   <= pre_nxt;
    end
    if (cmd.load_out) begin
      out_r <= {chain_r[3], chain_r[2], chain_r[1], chain_r[0]};
    end
  end

endmodule

`default_nettype wire

/* hdl/md5_ctrl.sv */
`default_nettype none

module md5_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  input  wire logic              in_has,
  input  wire logic              in_last,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  input  wire md5_pkg::md5_sts_t sts,
  output md5_pkg::md5_cmd_t      cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FIN
  } st_t;

  st_t  st_r, st_nxt;
  st_t  ret_r, ret_nxt;
  logic first_r, first_nxt;
  logic lenph_r, lenph_nxt;
  logic out_valid_r, out_valid_nxt;
  logic lenph_now;

  assign in_tready  = (st_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign lenph_now  = lenph_r || (!first_r && sts.pos_at_56);

  always_comb begin
    cmd           = '0;
    cmd.byte_sel  = md5_pkg::BSEL_IN;
    st_nxt        = st_r;
    ret_nxt       = ret_r;
    first_nxt     = first_r;
    lenph_nxt     = lenph_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (st_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_last) begin
            first_nxt = 1'b1;
            lenph_nxt = 1'b0;
          end
          if (in_has) begin
            cmd.put_byte = 1'b1;
            cmd.add_len  = 1'b1;
            if (sts.pos_at_63) begin
              cmd.round_init = 1'b1;
              st_nxt         = ST_ROUND;
              ret_nxt        = in_last ? ST_PAD : ST_IDLE;
            end else if (in_last) begin
              st_nxt = ST_PAD;
            end
          end else if (in_last) begin
            st_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd.put_byte = 1'b1;
        if (first_r) begin
          cmd.byte_sel = md5_pkg::BSEL_MARK;
        end else if (lenph_now) begin
          cmd.byte_sel = md5_pkg::BSEL_LEN;
        end else begin
          cmd.byte_sel = md5_pkg::BSEL_ZERO;
        end
        first_nxt = 1'b0;
        lenph_nxt = lenph_now;
        if (sts.pos_at_63) begin
          cmd.round_init = 1'b1;
          st_nxt         = ST_ROUND;
          ret_nxt        = lenph_now ? ST_FIN : ST_PAD;
        end
      end
      ST_ROUND: begin
        cmd.round_step = 1'b1;
        if (sts.rnd_last) begin
          st_nxt = ret_r;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out  = 1'b1;
          cmd.reinit    = 1'b1;
          out_valid_nxt = 1'b1;
          st_nxt        = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      ret_r       <= ST_IDLE;
      first_r     <= 1'b0;
      lenph_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      ret_r       <= ret_nxt;
      first_r     <= first_nxt;
      lenph_r     <= lenph_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_tready))
    else $error("digest loaded over an unread result");

  a_wrap_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.put_byte && sts.pos_at_63) |=> (st_r == ST_ROUND))
    else $error("full block did not start the rounds");

  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_ROUND && sts.rnd_last) |=> (st_r != ST_ROUND))
    else $error("round run did not end after the last round");

  a_len_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_PAD && lenph_r) |-> (cmd.byte_sel == md5_pkg::BSEL_LEN))
    else $error("length field interrupted by padding bytes");

  a_fin_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_FIN) |-> (!sts.pos_at_56 && !sts.pos_at_63))
    else $error("message finished off a block boundary");

endmodule

`default_nettype wire

/* hdl/md5_message_digest.sv */
// MD5 hash engine taking one message byte per beat. A beat with in_tuser low
// carries no byte, so a beat with in_tuser low and in_tlast high ends a message
// without adding data (an empty message is hashed this way). Every 64th byte
// starts a block run on the single shared round unit, one round per cycle,
// during which no beat is taken. After the last beat the block appends the
// padding and length one byte per cycle outside the block runs (9 to 72
// bytes), runs one or two more blocks, and then loads the four chaining words
// into the output register. The result waits there while the next message is
// already being accepted; a new result is held back only if the previous one
// has not yet been taken.
`default_nettype none

module md5_message_digest (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,  // Bits: data_byte.
  input  wire logic         in_tuser,  // Bits: has_byte.
  input  wire logic         in_tlast,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [127:0]      out_tdata  // Bits: word_d, word_c, word_b, word_a.
);

  md5_pkg::md5_cmd_t cmd;
  md5_pkg::md5_sts_t sts;

  md5_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_has     (in_tuser),
    .in_last    (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  md5_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_byte (in_tdata),
    .cmd     (cmd),
    .sts     (sts),
    .digest  (out_tdata)
  );

endmodule

`default_nettype wire
